>>> design/luenberger_observer_step_defines.svh
// Assertion macros for the observer step design
`ifndef LUENBERGER_OBSERVER_STEP_DEFINES_SVH
`define LUENBERGER_OBSERVER_STEP_DEFINES_SVH
`ifndef SYNTH
`define LOBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LOBS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LOBS_ASSERT(lbl, prop, msg)
`define LOBS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> design/lobs_pkg.sv
package lobs_pkg;

    // Sizes of the observer
    localparam int STATES    = 4;
    localparam int INPUTS    = 2;
    localparam int OUTPUTS   = 2;
    localparam int FRAC_BITS = 16;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int SEL_W     = 3;
    localparam int RC_W      = 2;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam int SW = (STATES  > 1) ? $clog2(STATES)  : 1;
    localparam int IW = (INPUTS  > 1) ? $clog2(INPUTS)  : 1;
    localparam int OW = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
    localparam int IDX_W = (SW >= IW && SW >= OW) ? SW : ((IW >= OW) ? IW : OW);

    // Coefficient store layout, row major per matrix
    localparam int A_BASE     = 0;
    localparam int B_BASE     = A_BASE + STATES * STATES;
    localparam int C_BASE     = B_BASE + STATES * INPUTS;
    localparam int D_BASE     = C_BASE + OUTPUTS * STATES;
    localparam int L_BASE     = D_BASE + OUTPUTS * INPUTS;
    localparam int COEF_DEPTH = L_BASE + STATES * OUTPUTS;
    localparam int ADDR_W     = $clog2(COEF_DEPTH);

    // Digit-serial multiplier
    localparam int DIGIT_W = 8;
    localparam int DIGITS  = DATA_W / DIGIT_W;
    localparam int DCNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int MCAND_W = DATA_W + 1;
    localparam int PROD_W  = DATA_W + MCAND_W;
    localparam int ACC_W   = PROD_W + $clog2(STATES + INPUTS + OUTPUTS);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_COEF  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MEAS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CTRL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STEP  = 3'd4;

    // Matrix select codes
    localparam logic [SEL_W-1:0] SEL_A = 3'd0;
    localparam logic [SEL_W-1:0] SEL_B = 3'd1;
    localparam logic [SEL_W-1:0] SEL_C = 3'd2;
    localparam logic [SEL_W-1:0] SEL_D = 3'd3;
    localparam logic [SEL_W-1:0] SEL_L = 3'd4;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_STATES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS = 2'd2;
    localparam logic [2:0] CFG_STATES_RST  = 3'd4;
    localparam logic [1:0] CFG_INPUTS_RST  = 2'd2;
    localparam logic [1:0] CFG_OUTPUTS_RST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_MUL,
        ST_ROUND,
        ST_COMMIT
    } obs_state_t;

    // Kind of product term: C*x, D*u, A*x, B*u, L*e
    typedef enum logic [2:0] {
        T_CX,
        T_DU,
        T_AX,
        T_BU,
        T_LE
    } term_t;

    typedef struct packed {
        logic                      clear;
        logic                      load;
        logic [DATA_W-1:0]         coef;
        logic signed [MCAND_W-1:0] mcand;
    } mac_cmd_t;

endpackage

>>> design/lobs_in_if.sv
interface lobs_in_if
    import lobs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [SEL_W-1:0]         matrix_select;
    logic [RC_W-1:0]          row_index;
    logic [RC_W-1:0]          col_index;
    logic signed [DATA_W-1:0] data_value;
    logic                     zero_input;

    modport source (
        output valid, command, matrix_select, row_index, col_index, data_value, zero_input,
        input  ready
    );
    modport sink (
        input  valid, command, matrix_select, row_index, col_index, data_value, zero_input,
        output ready
    );
endinterface

>>> design/lobs_out_if.sv
interface lobs_out_if
    import lobs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] predicted_output;
    logic                     output_index;
    logic                     last_output;

    modport source (
        output valid, predicted_output, output_index, last_output,
        input  ready
    );
    modport sink (
        input  valid, predicted_output, output_index, last_output,
        output ready
    );
endinterface

>>> design/lobs_ram.sv
module lobs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> design/lobs_mac.sv
module lobs_mac
    import lobs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_cmd_t                 cmd,
    output logic                     busy,
    output logic signed [DATA_W-1:0] rounded
);
    localparam int SH_W = ACC_W - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SH_W-1:0] SAT_MAX = {{(SH_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SH_W-1:0] SAT_MIN = {{(SH_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           acc_next;
    logic [DATA_W-1:0]                 coef_reg;
    logic signed [MCAND_W-1:0]         mcand_reg;
    logic [DCNT_W-1:0]                 digit_reg;
    logic                              busy_reg;
    logic signed [DIGIT_W:0]           digit_s;
    logic signed [MCAND_W+DIGIT_W:0]   partial;
    logic signed [ACC_W-1:0]           partial_ext;
    logic signed [ACC_W-1:0]           biased;
    logic signed [SH_W-1:0]            shifted;

    // Form one digit product; the top digit of the coefficient is signed
    always_comb
    begin
        if (digit_reg == DCNT_W'(DIGITS - 1))
        begin
            digit_s = {coef_reg[DIGIT_W-1], coef_reg[DIGIT_W-1:0]};
        end
        else
        begin
            digit_s = {1'b0, coef_reg[DIGIT_W-1:0]};
        end
        partial     = mcand_reg * digit_s;
        partial_ext = ACC_W'(partial) <<< (int'(digit_reg) * DIGIT_W);
        acc_next    = acc_reg + partial_ext;
    end

    // Advance the digit loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            digit_reg <= '0;
        end
        else if (cmd.load)
        begin
            busy_reg  <= 1'b1;
            digit_reg <= '0;
        end
        else if (busy_reg)
        begin
            digit_reg <= digit_reg + 1'b1;
            if (digit_reg == DCNT_W'(DIGITS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Hold operands and accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.load)
        begin
            coef_reg  <= cmd.coef;
            mcand_reg <= cmd.mcand;
        end
        else if (busy_reg)
        begin
            coef_reg <= coef_reg >> DIGIT_W;
        end
    end

    // Round half up, drop fraction, saturate
    always_comb
    begin
        biased  = acc_reg + HALF;
        shifted = biased[ACC_W-1:FRAC_BITS];
        if (shifted > SAT_MAX)
        begin
            rounded = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (shifted < SAT_MIN)
        begin
            rounded = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            rounded = shifted[DATA_W-1:0];
        end
    end

    assign busy = busy_reg;
endmodule

>>> design/luenberger_observer_step.sv
// Discrete Luenberger observer step in Q16.16. Command words write one coefficient of A, B, C,
// D or L, one state element, or buffer one measurement or control element. A step word
// computes y = Cx + Du, emits each y element on the result channel (last one flagged), then
// updates x = Ax + Bu + L(m - y) from the old x. All products go through one shared
// multiplier that walks the coefficient 8 bits per cycle; each product term passes through a
// coefficient memory read, an operand load, 4 digits and a hand-off, and each sum is then
// rounded. Before it emits a y word, the step waits for the result channel to take the last.
`include "luenberger_observer_step_defines.svh"
module luenberger_observer_step
    import lobs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    lobs_in_if.sink              request,
    lobs_out_if.source           result
);
    obs_state_t state_reg, state_next;
    term_t      term_reg, term_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic             zu_reg;
    logic [2:0]       n_cfg_reg;
    logic [1:0]       p_cfg_reg;
    logic [1:0]       q_cfg_reg;
    logic [IDX_W-1:0] n_last, p_last, q_last;

    logic signed [DATA_W-1:0] x_reg    [STATES];
    logic signed [DATA_W-1:0] nx_reg   [STATES];
    logic signed [DATA_W-1:0] meas_reg [OUTPUTS];
    logic signed [DATA_W-1:0] ctrl_reg [INPUTS];
    logic signed [DATA_W-1:0] y_reg    [OUTPUTS];

    logic [COEF_DEPTH-1:0] coef_vld_reg;
    logic                  rd_vld_reg;
    logic                  coef_we;
    logic [ADDR_W-1:0]     coef_waddr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_W-1:0]     ram_rdata;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_idx_reg;
    logic                     out_last_reg;

    logic accept;
    logic mac_clear, out_load, y_wr, nx_wr, commit;
    logic mac_busy;
    logic signed [DATA_W-1:0]  mac_rounded;
    logic signed [MCAND_W-1:0] mcand;
    mac_cmd_t mac_cmd;

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;

    // Clamp configured sizes to last indexes
    always_comb
    begin
        if (n_cfg_reg == '0)
            n_last = '0;
        else if (int'(n_cfg_reg) > STATES)
            n_last = IDX_W'(STATES - 1);
        else
            n_last = IDX_W'(n_cfg_reg - 3'd1);
        if (p_cfg_reg == '0)
            p_last = '0;
        else if (int'(p_cfg_reg) > INPUTS)
            p_last = IDX_W'(INPUTS - 1);
        else
            p_last = IDX_W'(p_cfg_reg - 2'd1);
        if (q_cfg_reg == '0)
            q_last = '0;
        else if (int'(q_cfg_reg) > OUTPUTS)
            q_last = IDX_W'(OUTPUTS - 1);
        else
            q_last = IDX_W'(q_cfg_reg - 2'd1);
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_cfg_reg <= CFG_STATES_RST;
            p_cfg_reg <= CFG_INPUTS_RST;
            q_cfg_reg <= CFG_OUTPUTS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_STATES:  n_cfg_reg <= cfg_data;
                CFG_INPUTS:  p_cfg_reg <= cfg_data[1:0];
                CFG_OUTPUTS: q_cfg_reg <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    // Decode coefficient writes into the store address
    always_comb
    begin
        coef_we    = 1'b0;
        coef_waddr = '0;
        if (accept && request.command == CMD_COEF)
        begin
            case (request.matrix_select)
                SEL_A:
                    if (int'(request.row_index) < STATES && int'(request.col_index) < STATES)
                    begin
                        coef_we    = 1'b1;
                        coef_waddr = ADDR_W'(A_BASE + int'(request.row_index) * STATES
                                     + int'(request.col_index));
                    end
                SEL_B:
                    if (int'(request.row_index) < STATES && int'(request.col_index) < INPUTS)
                    begin
                        coef_we    = 1'b1;
                        coef_waddr = ADDR_W'(B_BASE + int'(request.row_index) * INPUTS
                                     + int'(request.col_index));
                    end
                SEL_C:
                    if (int'(request.row_index) < OUTPUTS && int'(request.col_index) < STATES)
                    begin
                        coef_we    = 1'b1;
                        coef_waddr = ADDR_W'(C_BASE + int'(request.row_index) * STATES
                                     + int'(request.col_index));
                    end
                SEL_D:
                    if (int'(request.row_index) < OUTPUTS && int'(request.col_index) < INPUTS)
                    begin
                        coef_we    = 1'b1;
                        coef_waddr = ADDR_W'(D_BASE + int'(request.row_index) * INPUTS
                                     + int'(request.col_index));
                    end
                SEL_L:
                    if (int'(request.row_index) < STATES && int'(request.col_index) < OUTPUTS)
                    begin
                        coef_we    = 1'b1;
                        coef_waddr = ADDR_W'(L_BASE + int'(request.row_index) * OUTPUTS
                                     + int'(request.col_index));
                    end
                default: ;
            endcase
        end
    end

    // Address of the coefficient for the current term
    always_comb
    begin
        case (term_reg)
            T_CX:    rd_addr = ADDR_W'(C_BASE + int'(i_reg) * STATES  + int'(j_reg));
            T_DU:    rd_addr = ADDR_W'(D_BASE + int'(i_reg) * INPUTS  + int'(j_reg));
            T_AX:    rd_addr = ADDR_W'(A_BASE + int'(i_reg) * STATES  + int'(j_reg));
            T_BU:    rd_addr = ADDR_W'(B_BASE + int'(i_reg) * INPUTS  + int'(j_reg));
            T_LE:    rd_addr = ADDR_W'(L_BASE + int'(i_reg) * OUTPUTS + int'(j_reg));
            default: rd_addr = '0;
        endcase
    end

    lobs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (request.data_value),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Track written coefficients; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (coef_we)
            begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
            rd_vld_reg <= coef_vld_reg[rd_addr];
        end
    end

    // Pick the vector operand for the term
    always_comb
    begin
        case (term_reg)
            T_CX, T_AX:
                mcand = MCAND_W'(x_reg[j_reg[SW-1:0]]);
            T_DU, T_BU:
                mcand = zu_reg ? '0 : MCAND_W'(ctrl_reg[j_reg[IW-1:0]]);
            T_LE:
                mcand = MCAND_W'(meas_reg[j_reg[OW-1:0]]) - MCAND_W'(y_reg[j_reg[OW-1:0]]);
            default:
                mcand = '0;
        endcase
    end

    always_comb
    begin
        mac_cmd.clear = mac_clear;
        mac_cmd.load  = (state_reg == ST_LOAD);
        mac_cmd.coef  = rd_vld_reg ? ram_rdata : '0;
        mac_cmd.mcand = mcand;
    end

    lobs_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mac_cmd),
        .busy    (mac_busy),
        .rounded (mac_rounded)
    );

    // Sequence terms and sums
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        mac_clear  = 1'b0;
        out_load   = 1'b0;
        y_wr       = 1'b0;
        nx_wr      = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (accept && request.command == CMD_STEP)
                begin
                    mac_clear  = 1'b1;
                    term_next  = T_CX;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_FETCH;
                end
            ST_FETCH:
                state_next = ST_LOAD;
            ST_LOAD:
                state_next = ST_MUL;
            ST_MUL:
                if (!mac_busy)
                begin
                    state_next = ST_FETCH;
                    case (term_reg)
                        T_CX:
                            if (j_reg == n_last)
                            begin
                                term_next = T_DU;
                                j_next    = '0;
                            end
                            else
                                j_next = j_reg + 1'b1;
                        T_DU:
                            if (j_reg == p_last)
                                state_next = ST_ROUND;
                            else
                                j_next = j_reg + 1'b1;
                        T_AX:
                            if (j_reg == n_last)
                            begin
                                term_next = T_BU;
                                j_next    = '0;
                            end
                            else
                                j_next = j_reg + 1'b1;
                        T_BU:
                            if (j_reg == p_last)
                            begin
                                term_next = T_LE;
                                j_next    = '0;
                            end
                            else
                                j_next = j_reg + 1'b1;
                        T_LE:
                            if (j_reg == q_last)
                                state_next = ST_ROUND;
                            else
                                j_next = j_reg + 1'b1;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            ST_ROUND:
                if (term_reg == T_DU)
                begin
                    if (!(out_valid_reg && !result.ready))
                    begin
                        out_load   = 1'b1;
                        y_wr       = 1'b1;
                        mac_clear  = 1'b1;
                        j_next     = '0;
                        state_next = ST_FETCH;
                        if (i_reg == q_last)
                        begin
                            term_next = T_AX;
                            i_next    = '0;
                        end
                        else
                        begin
                            term_next = T_CX;
                            i_next    = i_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    nx_wr     = 1'b1;
                    mac_clear = 1'b1;
                    j_next    = '0;
                    if (i_reg == n_last)
                        state_next = ST_COMMIT;
                    else
                    begin
                        term_next  = T_AX;
                        i_next     = i_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            ST_COMMIT:
            begin
                commit     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= T_CX;
            i_reg     <= '0;
            j_reg     <= '0;
            zu_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (accept && request.command == CMD_STEP)
            begin
                zu_reg <= request.zero_input;
            end
        end
    end

    // Update state, buffers and per-step results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STATES; k++)
            begin
                x_reg[k] <= '0;
            end
            for (int k = 0; k < OUTPUTS; k++)
            begin
                meas_reg[k] <= '0;
            end
            for (int k = 0; k < INPUTS; k++)
            begin
                ctrl_reg[k] <= '0;
            end
        end
        else
        begin
            if (accept && request.command == CMD_STATE && int'(request.row_index) < STATES)
            begin
                x_reg[request.row_index[SW-1:0]] <= request.data_value;
            end
            if (accept && request.command == CMD_MEAS && int'(request.row_index) < OUTPUTS)
            begin
                meas_reg[request.row_index[OW-1:0]] <= request.data_value;
            end
            if (accept && request.command == CMD_CTRL && int'(request.row_index) < INPUTS)
            begin
                ctrl_reg[request.row_index[IW-1:0]] <= request.data_value;
            end
            if (commit)
            begin
                for (int k = 0; k < STATES; k++)
                begin
                    if (k <= int'(n_last))
                    begin
                        x_reg[k] <= nx_reg[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (y_wr)
        begin
            y_reg[i_reg[OW-1:0]] <= mac_rounded;
        end
        if (nx_wr)
        begin
            nx_reg[i_reg[SW-1:0]] <= mac_rounded;
        end
        if (out_load)
        begin
            out_data_reg <= mac_rounded;
            out_idx_reg  <= i_reg[0];
            out_last_reg <= (i_reg == q_last);
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.predicted_output = out_data_reg;
    assign result.output_index     = out_idx_reg;
    assign result.last_output      = out_last_reg;

    `LOBS_ASSERT(a_mac_in_mul, mac_busy |-> state_reg == ST_MUL, "multiplier busy outside MUL")
    `LOBS_ASSERT(a_commit_idle, state_reg == ST_COMMIT |=> state_reg == ST_IDLE, "no idle after commit")
    `LOBS_ASSERT(a_no_overwrite, out_load |-> !(out_valid_reg && !result.ready), "result overwritten")
    `LOBS_ASSERT_RST(a_rst_quiet, !rst_n |-> !result.valid, "result valid in reset")
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench
    import lobs_pkg::*;
();

    // One command or step word as presented on the request channel
    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [SEL_W-1:0]         sel;
        logic [RC_W-1:0]          row;
        logic [RC_W-1:0]          col;
        logic signed [DATA_W-1:0] data;
        logic                     zu;
    } obs_word_t;

    // One element of y as expected on the result channel
    typedef struct {
        logic signed [DATA_W-1:0] y;
        logic                     idx;
        logic                     last;
    } y_word_t;

    typedef logic signed [127:0] wide_t;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic [CMD_W-1:0] CMD_LAST = 3'd7;
    localparam logic [SEL_W-1:0] SEL_LAST = 3'd7;
    localparam int SETTLE_CYCLES = 400;

    class observer_scoreboard;
        logic signed [DATA_W-1:0] x_est [STATES];
        logic signed [DATA_W-1:0] a_m [STATES*STATES];
        logic signed [DATA_W-1:0] b_m [STATES*INPUTS];
        logic signed [DATA_W-1:0] c_m [OUTPUTS*STATES];
        logic signed [DATA_W-1:0] d_m [OUTPUTS*INPUTS];
        logic signed [DATA_W-1:0] l_m [STATES*OUTPUTS];
        logic signed [DATA_W-1:0] meas [OUTPUTS];
        logic signed [DATA_W-1:0] ctrl [INPUTS];
        logic [2:0] n_reg;
        logic [1:0] p_reg;
        logic [1:0] q_reg;
        y_word_t pending_y[$];
        int errors;

        function new();
            foreach (x_est[i]) x_est[i] = '0;
            foreach (a_m[i]) a_m[i] = '0;
            foreach (b_m[i]) b_m[i] = '0;
            foreach (c_m[i]) c_m[i] = '0;
            foreach (d_m[i]) d_m[i] = '0;
            foreach (l_m[i]) l_m[i] = '0;
            foreach (meas[i]) meas[i] = '0;
            foreach (ctrl[i]) ctrl[i] = '0;
            n_reg = CFG_STATES_RST;
            p_reg = CFG_INPUTS_RST;
            q_reg = CFG_OUTPUTS_RST;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_STATES) n_reg = val[2:0];
            else if (idx == CFG_INPUTS) p_reg = val[1:0];
            else if (idx == CFG_OUTPUTS) q_reg = val[1:0];
        endfunction

        function int clamp_size(int v, int maxv);
            if (v < 1) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        // Round half up, then saturate to Q16.16
        function logic signed [DATA_W-1:0] round_sat(wide_t acc);
            wide_t s;
            s = (acc + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (s > wide_t'(Q_MAX)) return Q_MAX;
            if (s < wide_t'(Q_MIN)) return Q_MIN;
            return s[DATA_W-1:0];
        endfunction

        function void note_word(obs_word_t w);
            int n, p, q;
            wide_t acc;
            logic signed [DATA_W-1:0] u [INPUTS];
            logic signed [DATA_W-1:0] y [OUTPUTS];
            logic signed [DATA_W-1:0] nx [STATES];
            y_word_t e;
            case (w.cmd)
                CMD_COEF:
                begin
                    if (w.sel == SEL_A && w.row < STATES && w.col < STATES)
                        a_m[w.row*STATES + w.col] = w.data;
                    else if (w.sel == SEL_B && w.row < STATES && w.col < INPUTS)
                        b_m[w.row*INPUTS + w.col] = w.data;
                    else if (w.sel == SEL_C && w.row < OUTPUTS && w.col < STATES)
                        c_m[w.row*STATES + w.col] = w.data;
                    else if (w.sel == SEL_D && w.row < OUTPUTS && w.col < INPUTS)
                        d_m[w.row*INPUTS + w.col] = w.data;
                    else if (w.sel == SEL_L && w.row < STATES && w.col < OUTPUTS)
                        l_m[w.row*OUTPUTS + w.col] = w.data;
                end
                CMD_STATE: if (w.row < STATES) x_est[w.row] = w.data;
                CMD_MEAS:  if (w.row < OUTPUTS) meas[w.row] = w.data;
                CMD_CTRL:  if (w.row < INPUTS) ctrl[w.row] = w.data;
                CMD_STEP:
                begin
                    n = clamp_size(n_reg, STATES);
                    p = clamp_size(p_reg, INPUTS);
                    q = clamp_size(q_reg, OUTPUTS);
                    foreach (u[j]) u[j] = w.zu ? '0 : ctrl[j];
                    foreach (y[i]) y[i] = '0;
                    // y = Cx + Du
                    for (int i = 0; i < q; i++)
                    begin
                        acc = '0;
                        for (int j = 0; j < n; j++)
                            acc += wide_t'(c_m[i*STATES + j]) * wide_t'(x_est[j]);
                        for (int j = 0; j < p; j++)
                            acc += wide_t'(d_m[i*INPUTS + j]) * wide_t'(u[j]);
                        y[i] = round_sat(acc);
                    end
                    // x = Ax + Bu + L(m - y), all from the old x
                    foreach (nx[i]) nx[i] = x_est[i];
                    for (int i = 0; i < n; i++)
                    begin
                        acc = '0;
                        for (int j = 0; j < n; j++)
                            acc += wide_t'(a_m[i*STATES + j]) * wide_t'(x_est[j]);
                        for (int j = 0; j < p; j++)
                            acc += wide_t'(b_m[i*INPUTS + j]) * wide_t'(u[j]);
                        for (int j = 0; j < q; j++)
                            acc += wide_t'(l_m[i*OUTPUTS + j])
                                   * (wide_t'(meas[j]) - wide_t'(y[j]));
                        nx[i] = round_sat(acc);
                    end
                    foreach (x_est[i]) x_est[i] = nx[i];
                    for (int i = 0; i < q; i++)
                    begin
                        e.y = y[i];
                        e.idx = i[0];
                        e.last = (i == q - 1);
                        pending_y.push_back(e);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic signed [DATA_W-1:0] y, logic idx, logic last);
            y_word_t e;
            if (pending_y.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected y word: y=%h idx=%0d last=%0d", y, idx, last);
                return;
            end
            e = pending_y.pop_front();
            if (y !== e.y || idx !== e.idx || last !== e.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("y mismatch: expected y=%h idx=%0d last=%0d, got y=%h idx=%0d last=%0d",
                             e.y, e.idx, e.last, y, idx, last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    bit busy_mode;

    lobs_in_if  req_if();
    lobs_out_if res_if();

    observer_scoreboard sb = new();

    luenberger_observer_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_if),
        .result    (res_if)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog
    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Note accepted words and check delivered y words
    always @(posedge clk)
    begin
        obs_word_t w;
        if (rst_n && req_if.valid && req_if.ready)
        begin
            w.cmd  = req_if.command;
            w.sel  = req_if.matrix_select;
            w.row  = req_if.row_index;
            w.col  = req_if.col_index;
            w.data = req_if.data_value;
            w.zu   = req_if.zero_input;
            sb.note_word(w);
        end
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_word(res_if.predicted_output, res_if.output_index, res_if.last_output);
    end

    function int pick_gap();
        int r;
        if (!busy_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Stall the result channel at random
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_if.ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic send_word(obs_word_t w);
        int g;
        req_if.valid         <= 1'b1;
        req_if.command       <= w.cmd;
        req_if.matrix_select <= w.sel;
        req_if.row_index     <= w.row;
        req_if.col_index     <= w.col;
        req_if.data_value    <= w.data;
        req_if.zero_input    <= w.zu;
        do @(posedge clk); while (!req_if.ready);
        g = pick_gap();
        if (g > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic put(logic [CMD_W-1:0] cmd, logic [SEL_W-1:0] sel, logic [RC_W-1:0] row,
                       logic [RC_W-1:0] col, logic signed [DATA_W-1:0] data, logic zu);
        obs_word_t w;
        w.cmd = cmd; w.sel = sel; w.row = row; w.col = col; w.data = data; w.zu = zu;
        send_word(w);
    endtask

    // Drop valid, drain all y words, then let the update of x finish
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_y.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold the enable high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    function logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return $signed($urandom) >>> $urandom_range(8, 14);
        endcase
    endfunction

    // Mostly well-formed commands; a few unknown codes and stray indexes
    task automatic send_random();
        obs_word_t w;
        int r;
        r = $urandom_range(0, 99);
        w.sel  = SEL_W'($urandom_range(SEL_A, SEL_L));
        w.row  = RC_W'($urandom);
        w.col  = RC_W'($urandom);
        w.data = rand_value();
        w.zu   = $urandom_range(0, 3) == 0;
        if (r < 40) w.cmd = CMD_COEF;
        else if (r < 50) w.cmd = CMD_STATE;
        else if (r < 58) w.cmd = CMD_MEAS;
        else if (r < 66) w.cmd = CMD_CTRL;
        else if (r < 92) w.cmd = CMD_STEP;
        else if (r < 96)
        begin
            w.cmd = CMD_W'($urandom_range(CMD_STEP + 1, CMD_LAST));
        end
        else
        begin
            w.cmd = CMD_COEF;
            w.sel = SEL_W'($urandom_range(SEL_L + 1, SEL_LAST));
        end
        send_word(w);
    endtask

    logic [2:0] n_set [7] = '{3'd4, 3'd0, 3'd7, 3'd1, 3'd3, 3'd2, 3'd4};
    logic [1:0] p_set [7] = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd1, 2'd2};
    logic [1:0] q_set [7] = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd1, 2'd2, 2'd2};

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        busy_mode = 1'b0;
        req_if.valid = 1'b0;
        req_if.command = CMD_COEF;
        req_if.matrix_select = SEL_A;
        req_if.row_index = '0;
        req_if.col_index = '0;
        req_if.data_value = '0;
        req_if.zero_input = 1'b0;
        res_if.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every command, ignored codes and stray indexes
        put(CMD_STEP, SEL_A, 2'd0, 2'd0, '0, 1'b0);
        put(CMD_COEF, SEL_A, 2'd0, 2'd0, Q_MAX, 1'b0);
        put(CMD_COEF, SEL_A, 2'd3, 2'd3, Q_MIN, 1'b0);
        put(CMD_COEF, SEL_B, 2'd3, 2'd1, Q_ONE, 1'b0);
        put(CMD_COEF, SEL_C, 2'd0, 2'd0, Q_MAX, 1'b0);
        put(CMD_COEF, SEL_C, 2'd1, 2'd3, Q_MIN, 1'b0);
        put(CMD_COEF, SEL_D, 2'd1, 2'd1, Q_MAX, 1'b0);
        put(CMD_COEF, SEL_L, 2'd0, 2'd1, Q_MIN, 1'b0);
        put(CMD_COEF, SEL_L, 2'd3, 2'd0, Q_MAX, 1'b0);
        put(CMD_STATE, SEL_A, 2'd0, 2'd0, Q_MAX, 1'b0);
        put(CMD_STATE, SEL_A, 2'd3, 2'd0, Q_MIN, 1'b0);
        put(CMD_MEAS, SEL_A, 2'd1, 2'd0, Q_MIN, 1'b0);
        put(CMD_CTRL, SEL_A, 2'd1, 2'd0, Q_MAX, 1'b0);
        put(CMD_COEF, SEL_B, 2'd0, 2'd3, Q_MAX, 1'b0);
        put(CMD_COEF, SEL_D, 2'd2, 2'd0, Q_MAX, 1'b0);
        put(CMD_MEAS, SEL_A, 2'd3, 2'd0, Q_MAX, 1'b0);
        put(CMD_CTRL, SEL_A, 2'd2, 2'd0, Q_MIN, 1'b0);
        put(CMD_LAST, SEL_A, 2'd0, 2'd0, Q_MAX, 1'b0);
        put(CMD_W'(CMD_STEP + 1), SEL_A, 2'd0, 2'd0, Q_MAX, 1'b0);
        put(CMD_COEF, SEL_LAST, 2'd0, 2'd0, Q_MAX, 1'b0);
        put(CMD_STEP, SEL_A, 2'd0, 2'd0, '0, 1'b0);
        put(CMD_STEP, SEL_A, 2'd0, 2'd0, '0, 1'b1);
        put(CMD_STEP, SEL_A, 2'd0, 2'd0, '0, 1'b0);

        // Random phases over several size settings
        foreach (n_set[k])
        begin
            wait_idle();
            write_reg(CFG_STATES, (k == 6) ? CFG_W'($urandom_range(0, 7)) : n_set[k]);
            write_reg(CFG_INPUTS, (k == 6) ? CFG_W'($urandom_range(0, 3)) : CFG_W'(p_set[k]));
            write_reg(CFG_OUTPUTS, (k == 6) ? CFG_W'($urandom_range(0, 3)) : CFG_W'(q_set[k]));
            cfg_wr_en <= 1'b0;
            busy_mode = (k % 3) != 1;
            repeat (150) send_random();
        end

        wait_idle();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/lobs_pkg.sv
design/lobs_in_if.sv
design/lobs_out_if.sv
design/lobs_ram.sv
design/lobs_mac.sv
design/luenberger_observer_step.sv
tb/sv/testbench.sv
